@@ rtl/sdepq_pkg.sv @@
`timescale 1ns / 1ps

package sdepq_pkg;

  localparam int CAPACITY = 16;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  typedef enum logic [2:0] {
    KIND_INSERT = 3'd0,
    KIND_REM_LO = 3'd1,
    KIND_REM_HI = 3'd2,
    KIND_RD_LO  = 3'd3,
    KIND_RD_HI  = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  // broadcast to every cell of the chain
  typedef struct packed {
    logic insert;      // place the new record, shift larger ones up
    logic shift_down;  // drop cell 0, every cell but the last takes its upper neighbor
  } cmd_t;

endpackage

@@ rtl/sdepq_cell.sv @@
`timescale 1ns / 1ps

module sdepq_cell (
  input  logic               clk_i,
  input  sdepq_pkg::cmd_t    cmd_i,
  input  logic               occupied_i,
  input  logic signed [15:0] new_rank_i,
  input  logic        [15:0] new_id_i,
  input  logic               lower_after_i,
  input  logic signed [15:0] lower_rank_i,
  input  logic        [15:0] lower_id_i,
  input  logic signed [15:0] upper_rank_i,
  input  logic        [15:0] upper_id_i,
  output logic               after_o,
  output logic signed [15:0] rank_o,
  output logic        [15:0] id_o
);
  import sdepq_pkg::*;

  logic signed [15:0] rank_q, rank_d;
  logic        [15:0] id_q, id_d;

  // new record belongs at or below this cell
  assign after_o = !occupied_i || (rank_q > new_rank_i);

  always_comb begin
    rank_d = rank_q;
    id_d   = id_q;
    if (cmd_i.insert) begin
      if (after_o && !lower_after_i) begin
        rank_d = new_rank_i;
        id_d   = new_id_i;
      end else if (after_o) begin
        rank_d = lower_rank_i;
        id_d   = lower_id_i;
      end
    end else if (cmd_i.shift_down) begin
      rank_d = upper_rank_i;
      id_d   = upper_id_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rank_q <= rank_d;
    id_q   <= id_d;
  end

  assign rank_o = rank_q;
  assign id_o   = id_q;

endmodule

@@ rtl/sorted_double_ended_priority_queue.sv @@
`timescale 1ns / 1ps
// Channel | valid      | stall       | payload
// in      | in_valid_i | in_stall_o  | kind_i, rank_in_i, id_in_i
// out     | out_valid_o| out_stall_i | status_o, found_o, rank_out_o, id_out_o, fill_o
//
// One request per cycle while in_stall_o is low; its result is registered and shows in the cycle after the transfer.
// The cell chain compares all slots with the new rank and shifts in the same cycle.
// Reset empties the queue (count only; slot contents stay undefined) and the output register.
// in_stall_o is high only while a result waits and out_stall_i is high.

module sorted_double_ended_priority_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic        [2:0]  kind_i,
  input  logic signed [15:0] rank_in_i,
  input  logic        [15:0] id_in_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic        [1:0]  status_o,
  output logic               found_o,
  output logic signed [15:0] rank_out_o,
  output logic        [15:0] id_out_o,
  output logic        [4:0]  fill_o
);
  import sdepq_pkg::*;

  logic [CNT_W-1:0] count_q, count_d, count_m1;
  logic             out_valid_q, out_valid_d;
  status_e          status_q, status_d;
  logic             found_q, found_d;
  logic signed [15:0] rank_q, rank_d;
  logic        [15:0] id_q, id_d;
  logic        [4:0]  fill_q, fill_d;

  logic               in_accept;
  cmd_t               cmd;
  logic [IDX_W-1:0]   top_idx;
  logic               empty, full;

  logic               cell_after [CAPACITY];
  logic signed [15:0] cell_rank  [CAPACITY];
  logic        [15:0] cell_id    [CAPACITY];

  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_accept  = in_valid_i && !in_stall_o;

  assign empty    = (count_q == '0);
  assign full     = (count_q == CNT_W'(CAPACITY));
  assign count_m1 = count_q - CNT_W'(1);
  assign top_idx  = count_m1[IDX_W-1:0];

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic               lo_after;
    logic signed [15:0] lo_rank, up_rank;
    logic        [15:0] lo_id, up_id;

    if (i == 0) begin : g_first
      assign lo_after = 1'b0;
      assign lo_rank  = rank_in_i;
      assign lo_id    = id_in_i;
    end else begin : g_mid
      assign lo_after = cell_after[i-1];
      assign lo_rank  = cell_rank[i-1];
      assign lo_id    = cell_id[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign up_rank = cell_rank[i];
      assign up_id   = cell_id[i];
    end else begin : g_notlast
      assign up_rank = cell_rank[i+1];
      assign up_id   = cell_id[i+1];
    end

    sdepq_cell u_cell (
      .clk_i        (clk_i),
      .cmd_i        (cmd),
      .occupied_i   (CNT_W'(i) < count_q),
      .new_rank_i   (rank_in_i),
      .new_id_i     (id_in_i),
      .lower_after_i(lo_after),
      .lower_rank_i (lo_rank),
      .lower_id_i   (lo_id),
      .upper_rank_i (up_rank),
      .upper_id_i   (up_id),
      .after_o      (cell_after[i]),
      .rank_o       (cell_rank[i]),
      .id_o         (cell_id[i])
    );
  end

  always_comb begin
    cmd      = '0;
    count_d  = count_q;
    status_d = ST_OK;
    found_d  = 1'b0;
    rank_d   = '0;
    id_d     = '0;
    if (in_accept) begin
      case (kind_e'(kind_i))
        KIND_INSERT: begin
          if (full) begin
            status_d = ST_FULL;
          end else begin
            cmd.insert = 1'b1;
            count_d    = count_q + CNT_W'(1);
          end
        end
        KIND_REM_LO: begin
          if (empty) begin
            status_d = ST_EMPTY;
          end else begin
            cmd.shift_down = 1'b1;
            count_d        = count_m1;
            found_d        = 1'b1;
            rank_d         = cell_rank[0];
            id_d           = cell_id[0];
          end
        end
        KIND_REM_HI: begin
          if (empty) begin
            status_d = ST_EMPTY;
          end else begin
            count_d = count_m1;
            found_d = 1'b1;
            rank_d  = cell_rank[top_idx];
            id_d    = cell_id[top_idx];
          end
        end
        KIND_RD_LO: begin
          if (empty) begin
            status_d = ST_EMPTY;
          end else begin
            found_d = 1'b1;
            rank_d  = cell_rank[0];
            id_d    = cell_id[0];
          end
        end
        KIND_RD_HI: begin
          if (empty) begin
            status_d = ST_EMPTY;
          end else begin
            found_d = 1'b1;
            rank_d  = cell_rank[top_idx];
            id_d    = cell_id[top_idx];
          end
        end
        default: begin
          status_d = ST_OK;
        end
      endcase
    end
    fill_d = 5'(count_d);
  end

  always_comb begin
    if (in_accept) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      status_q <= status_d;
      found_q  <= found_d;
      rank_q   <= rank_d;
      id_q     <= id_d;
      fill_q   <= fill_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign found_o     = found_q;
  assign rank_out_o  = rank_q;
  assign id_out_o    = id_q;
  assign fill_o      = fill_q;

`ifndef NO_ASSERTIONS
  a_full_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && kind_i == KIND_INSERT && full) |=>
      (status_q == ST_FULL && !found_q && $stable(count_q)))
    else $error("insert into full queue not dropped");

  a_found_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && found_q) |-> (status_q == ST_OK))
    else $error("record returned with error status");

  a_remove_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && (kind_i == KIND_REM_LO || kind_i == KIND_REM_HI) && !empty) |=>
      (count_q == $past(count_m1) && fill_q == 5'(count_q)))
    else $error("remove did not decrement fill");

  a_sorted_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q >= CNT_W'(2)) |-> (cell_rank[0] <= cell_rank[1]))
    else $error("lowest slots out of order");
`endif

endmodule

@@ dv/tb_sorted_double_ended_priority_queue.sv @@
`timescale 1ns / 1ps

module tb_sorted_double_ended_priority_queue;
  import sdepq_pkg::*;

  localparam logic [2:0] KIND_SPARE_LO = 3'd5;
  localparam logic [2:0] KIND_SPARE_HI = 3'd7;
  localparam int N_RANDOM  = 400;
  localparam int STALL_LIM = 400;

  typedef struct {
    logic [2:0]         kind;
    logic signed [15:0] rank;
    logic [15:0]        id;
  } request_t;

  typedef struct {
    logic signed [15:0] rank;
    logic [15:0]        id;
  } record_t;

  typedef struct {
    logic [1:0]         status;
    logic               found;
    logic signed [15:0] rank;
    logic [15:0]        id;
    logic [4:0]         fill;
  } result_t;

  logic               clk_i;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic        [2:0]  kind_i = KIND_INSERT;
  logic signed [15:0] rank_in_i = '0;
  logic        [15:0] id_in_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic        [1:0]  status_o;
  logic               found_o;
  logic signed [15:0] rank_out_o;
  logic        [15:0] id_out_o;
  logic        [4:0]  fill_o;

  request_t    requests_todo[$];
  result_t     due_results[$];
  record_t     sorted_records[$];

  int unsigned errors = 0;
  int unsigned n_accepted = 0;
  int unsigned n_inserted = 0;
  int unsigned n_dropped = 0;
  int unsigned n_empty = 0;
  int unsigned peak_fill = 0;
  int unsigned send_wait = 0;
  int unsigned take_wait = 0;
  int unsigned quiet_cycles = 0;
  bit          send_burst = 1'b0;
  bit          take_burst = 1'b0;

  sorted_double_ended_priority_queue DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .kind_i     (kind_i),
    .rank_in_i  (rank_in_i),
    .id_in_i    (id_in_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .status_o   (status_o),
    .found_o    (found_o),
    .rank_out_o (rank_out_o),
    .id_out_o   (id_out_o),
    .fill_o     (fill_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic int unsigned draw_wait(bit burst);
    return burst ? 0 : $urandom_range(0, 7);
  endfunction

  // Applies one request to the sorted record list and queues its result.
  task automatic apply_request(request_t req);
    result_t res;
    record_t rec;
    int      pos;
    res = '{status: ST_OK, found: 1'b0, rank: '0, id: '0, fill: '0};
    case (req.kind)
      KIND_INSERT: begin
        if (sorted_records.size() >= CAPACITY) begin
          res.status = ST_FULL;
          n_dropped++;
        end else begin
          pos = 0;
          while (pos < sorted_records.size() &&
                 $signed(sorted_records[pos].rank) <= $signed(req.rank))
            pos++;
          rec.rank = req.rank;
          rec.id   = req.id;
          sorted_records.insert(pos, rec);
          n_inserted++;
        end
      end
      KIND_REM_LO, KIND_REM_HI, KIND_RD_LO, KIND_RD_HI: begin
        if (sorted_records.size() == 0) begin
          res.status = ST_EMPTY;
          n_empty++;
        end else begin
          if (req.kind == KIND_REM_LO || req.kind == KIND_RD_LO)
            rec = sorted_records[0];
          else
            rec = sorted_records[sorted_records.size() - 1];
          if (req.kind == KIND_REM_LO)
            sorted_records.delete(0);
          else if (req.kind == KIND_REM_HI)
            sorted_records.delete(sorted_records.size() - 1);
          res.found = 1'b1;
          res.rank  = rec.rank;
          res.id    = rec.id;
        end
      end
      default: ;
    endcase
    res.fill = 5'(sorted_records.size());
    if (sorted_records.size() > peak_fill)
      peak_fill = sorted_records.size();
    due_results.push_back(res);
  endtask

  task automatic add_request(logic [2:0] kind, logic signed [15:0] rank, logic [15:0] id);
    request_t req;
    req.kind = kind;
    req.rank = rank;
    req.id   = id;
    requests_todo.push_back(req);
  endtask

  // Driver
  always @(posedge clk_i or negedge rst_ni) begin : driver_blk
    request_t req;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      send_wait  <= 0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        req.kind = kind_i;
        req.rank = rank_in_i;
        req.id   = id_in_i;
        apply_request(req);
        n_accepted++;
      end
      if (in_valid_i && in_stall_o) begin
        // hold the stalled payload
      end else if (send_wait != 0) begin
        in_valid_i <= 1'b0;
        send_wait  <= send_wait - 1;
      end else if (requests_todo.size() != 0) begin
        req = requests_todo[0];
        requests_todo.delete(0);
        kind_i     <= req.kind;
        rank_in_i  <= req.rank;
        id_in_i    <= req.id;
        in_valid_i <= 1'b1;
        if ($urandom_range(0, 39) == 0)
          send_burst = ~send_burst;
        send_wait  <= draw_wait(send_burst);
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Monitor
  always @(posedge clk_i or negedge rst_ni) begin : monitor_blk
    result_t exp;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      take_wait = 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (due_results.size() == 0) begin
          $error("result transfer with nothing outstanding");
          errors++;
        end else begin
          exp = due_results[0];
          due_results.delete(0);
          if (status_o !== exp.status) begin
            $error("status: expected %0d, got %0d", exp.status, status_o);
            errors++;
          end
          if (found_o !== exp.found) begin
            $error("found: expected %0d, got %0d", exp.found, found_o);
            errors++;
          end
          if (rank_out_o !== exp.rank) begin
            $error("rank_out: expected %0d, got %0d", exp.rank, rank_out_o);
            errors++;
          end
          if (id_out_o !== exp.id) begin
            $error("id_out: expected %0d, got %0d", exp.id, id_out_o);
            errors++;
          end
          if (fill_o !== exp.fill) begin
            $error("fill: expected %0d, got %0d", exp.fill, fill_o);
            errors++;
          end
        end
        if ($urandom_range(0, 39) == 0)
          take_burst = ~take_burst;
        take_wait = draw_wait(take_burst);
      end else if (take_wait != 0) begin
        take_wait = take_wait - 1;
      end
      out_stall_i <= (take_wait != 0);
    end
  end

  // Watchdog: cycles without any transfer
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIM) begin
        $display("timeout: %0d requests pending, %0d results outstanding",
                 requests_todo.size(), due_results.size());
        $display("tb_sorted_double_ended_priority_queue: FAIL");
        $finish;
      end
    end
  end

  initial begin
    int          ins_pct;
    int unsigned pick;
    logic [2:0]  kind;
    logic signed [15:0] rank;

    // empty queue: every read and remove, plus an unused kind
    add_request(KIND_RD_LO,    16'sd5, 16'd5);
    add_request(KIND_RD_HI,    16'sd5, 16'd5);
    add_request(KIND_REM_LO,   16'sd0, 16'd0);
    add_request(KIND_REM_HI,   16'sd0, 16'd0);
    add_request(KIND_SPARE_LO, 16'sd0, 16'd0);
    // fill to capacity: extremes and ties
    add_request(KIND_INSERT, 16'sh8000, 16'd0);
    add_request(KIND_INSERT, 16'sh7FFF, 16'hFFFF);
    add_request(KIND_INSERT, 16'sd0,    16'd1);
    add_request(KIND_INSERT, 16'sd0,    16'd2);
    add_request(KIND_INSERT, -16'sd1,   16'd3);
    add_request(KIND_INSERT, 16'sh7FFF, 16'd4);
    add_request(KIND_INSERT, 16'sh8000, 16'd5);
    add_request(KIND_INSERT, 16'sd5,    16'hAAAA);
    add_request(KIND_INSERT, 16'sd5,    16'h5555);
    add_request(KIND_INSERT, -16'sd5,   16'd6);
    add_request(KIND_INSERT, 16'sd1,    16'd7);
    add_request(KIND_INSERT, 16'sd0,    16'd8);
    add_request(KIND_INSERT, 16'sd1000, 16'd9);
    add_request(KIND_INSERT, 16'sh5555, 16'd10);
    add_request(KIND_INSERT, 16'shAAAA, 16'd11);
    add_request(KIND_INSERT, 16'sd5,    16'd12);
    add_request(KIND_INSERT, 16'sd7,    16'd13);  // full: dropped
    add_request(KIND_RD_LO,  16'sd0,    16'd0);
    add_request(KIND_RD_HI,  16'sd0,    16'd0);
    add_request(KIND_REM_HI, 16'sd0,    16'd0);
    add_request(KIND_REM_LO, 16'sd0,    16'd0);
    add_request(KIND_SPARE_HI, 16'sh7FFF, 16'hFFFF);

    // random: alternate filling and draining phases
    for (int i = 0; i < N_RANDOM; i++) begin
      ins_pct = ((i / 40) % 2 == 0) ? 65 : 25;
      pick = $urandom_range(0, 99);
      if (pick < 3)
        kind = 3'($urandom_range(KIND_SPARE_LO, KIND_SPARE_HI));
      else if (pick < 3 + ins_pct)
        kind = KIND_INSERT;
      else
        kind = 3'($urandom_range(KIND_REM_LO, KIND_RD_HI));
      pick = $urandom_range(0, 9);
      if (pick < 4)
        rank = $signed(16'($urandom_range(0, 6))) - 16'sd3;
      else if (pick == 4)
        rank = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
      else
        rank = 16'($urandom_range(0, 65535));
      add_request(kind, rank, 16'($urandom_range(0, 65535)));
    end

    rst_ni = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    do @(posedge clk_i);
    while (requests_todo.size() != 0 || in_valid_i || due_results.size() != 0);
    repeat (10) @(posedge clk_i);

    if (due_results.size() != 0) begin
      $error("%0d expected results never arrived", due_results.size());
      errors++;
    end
    $display("%0d requests checked: %0d inserts, %0d dropped while full, %0d on empty",
             n_accepted, n_inserted, n_dropped, n_empty);
    $display("peak fill %0d of %0d, %0d mismatches", peak_fill, CAPACITY, errors);
    if (errors == 0)
      $display("tb_sorted_double_ended_priority_queue: PASS");
    else
      $display("tb_sorted_double_ended_priority_queue: FAIL");
    $finish;
  end

endmodule
